// ----- src/cpm_pkg.sv -----
// ----------------------------------------------------------------------------
// cpm_pkg: shared types and constants for the cylinder pair push unit
// Item layouts passed from the front part to the back part and the queue
// status that the front part uses for flow control.
// ----------------------------------------------------------------------------
package cpm_pkg;

	localparam int QDEPTH = 8;
	localparam int QPTR_W = 3;
	localparam int QCNT_W = 4;

	// Number of root bits and quotient bits, one per pipeline step.
	localparam int SQ_STEPS = 32;
	localparam int DV_STEPS = 32;

	typedef struct packed {
		logic               hit;
		logic               zero;
		logic               sx;
		logic               sz;
		logic [31:0]        mx;
		logic [31:0]        mz;
		logic [31:0]        rsum;
		logic [63:0]        lsq;
		logic signed [32:0] vert;
		logic [31:0]        vmag;
	} cpm_item_t;

	typedef struct packed {
		logic               hit;
		logic               horiz;
		logic               sx;
		logic               sz;
		logic signed [32:0] vert;
		logic [31:0]        len;
		logic [63:0]        nx;
		logic [63:0]        nz;
	} cpm_dv_t;

	typedef struct packed {
		logic              nempty;
		logic [QCNT_W-1:0] level;
	} cpm_qstat_t;

endpackage

// ----- src/cpm_front.sv -----
// ----------------------------------------------------------------------------
// cpm_front: input stage of the cylinder pair push unit
// Forms center differences, radius sum, vertical candidate, exact squares,
// and classifies the pair as colliding or not before queuing the item.
// ----------------------------------------------------------------------------
module cpm_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [31:0]        a_center_x,
	input  logic signed [31:0]        a_center_z,
	input  logic        [30:0]        a_radius,
	input  logic signed [31:0]        a_bottom,
	input  logic signed [31:0]        a_top,
	input  logic signed [31:0]        b_center_x,
	input  logic signed [31:0]        b_center_z,
	input  logic        [30:0]        b_radius,
	input  logic signed [31:0]        b_bottom,
	input  logic signed [31:0]        b_top,
	input  cpm_pkg::cpm_qstat_t       qstat,
	output logic                      push_v,
	output cpm_pkg::cpm_item_t        push_item
);
	import cpm_pkg::*;

	logic               v_s1, v_s2, v_s3;
	logic signed [32:0] dx_s1, dz_s1, up_s1, down_s1;
	logic [31:0]        rsum_s1;
	logic               ylap_s1;

	logic [31:0]        mx_s2, mz_s2, rsum_s2, vmag_s2;
	logic               sx_s2, sz_s2, ylap_s2;
	logic signed [32:0] vert_s2;

	logic [63:0]        sqx_s3, sqz_s3, rsq_s3;
	logic [31:0]        mx_s3, mz_s3, rsum_s3, vmag_s3;
	logic               sx_s3, sz_s3, ylap_s3;
	logic signed [32:0] vert_s3;

	logic [QCNT_W:0]    credit;
	logic               accept;
	logic signed [32:0] dx_neg, dz_neg;
	logic               vsel;
	logic [64:0]        lsq;

	// Items in flight here are counted against free queue entries, so the
	// front stages never have to stop.
	assign credit   = {1'b0, qstat.level} + (QCNT_W+1)'(v_s1) + (QCNT_W+1)'(v_s2)
		+ (QCNT_W+1)'(v_s3);
	assign in_stall = (credit >= (QCNT_W+1)'(QDEPTH));
	assign accept   = in_valid && !in_stall;

	assign dx_neg = -dx_s1;
	assign dz_neg = -dz_s1;
	assign vsel   = (up_s1 < down_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1   <= {b_center_x[31], b_center_x} - {a_center_x[31], a_center_x};
		dz_s1   <= {b_center_z[31], b_center_z} - {a_center_z[31], a_center_z};
		up_s1   <= {b_top[31], b_top} - {a_bottom[31], a_bottom};
		down_s1 <= {a_top[31], a_top} - {b_bottom[31], b_bottom};
		rsum_s1 <= {1'b0, a_radius} + {1'b0, b_radius};
		ylap_s1 <= (a_bottom < b_top) && (b_bottom < a_top);

		mx_s2   <= dx_s1[32] ? dx_neg[31:0] : dx_s1[31:0];
		mz_s2   <= dz_s1[32] ? dz_neg[31:0] : dz_s1[31:0];
		sx_s2   <= dx_s1[32];
		sz_s2   <= dz_s1[32];
		vert_s2 <= vsel ? up_s1 : -down_s1;
		vmag_s2 <= vsel ? up_s1[31:0] : down_s1[31:0];
		rsum_s2 <= rsum_s1;
		ylap_s2 <= ylap_s1;

		sqx_s3  <= mx_s2 * mx_s2;
		sqz_s3  <= mz_s2 * mz_s2;
		rsq_s3  <= rsum_s2 * rsum_s2;
		mx_s3   <= mx_s2;
		mz_s3   <= mz_s2;
		sx_s3   <= sx_s2;
		sz_s3   <= sz_s2;
		vert_s3 <= vert_s2;
		vmag_s3 <= vmag_s2;
		rsum_s3 <= rsum_s2;
		ylap_s3 <= ylap_s2;
	end

	assign lsq = {1'b0, sqx_s3} + {1'b0, sqz_s3};

	assign push_v = v_s3;
	always_comb begin
		push_item      = '0;
		push_item.hit  = (lsq < {1'b0, rsq_s3}) && ylap_s3;
		push_item.zero = (lsq == 65'd0);
		push_item.sx   = sx_s3;
		push_item.sz   = sz_s3;
		push_item.mx   = mx_s3;
		push_item.mz   = mz_s3;
		push_item.rsum = rsum_s3;
		push_item.lsq  = lsq[63:0];
		push_item.vert = vert_s3;
		push_item.vmag = vmag_s3;
	end

endmodule

// ----- src/cpm_queue.sv -----
// ----------------------------------------------------------------------------
// cpm_queue: short item queue between the front and back parts
// Register based first-in first-out store with a fill level.
// ----------------------------------------------------------------------------
module cpm_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_v,
	input  cpm_pkg::cpm_item_t  push_item,
	input  logic                pop,
	output cpm_pkg::cpm_item_t  head,
	output cpm_pkg::cpm_qstat_t qstat
);
	import cpm_pkg::*;

	cpm_item_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] level_q;
	logic              do_pop;

	assign do_pop = pop && (level_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push_v) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			level_q <= level_q + QCNT_W'(push_v) - QCNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_v) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	assign head         = mem_q[rd_ptr_q];
	assign qstat.nempty = (level_q != '0);
	assign qstat.level  = level_q;

endmodule

// ----- src/cpm_back.sv -----
// ----------------------------------------------------------------------------
// cpm_back: execution part of the cylinder pair push unit
// Pipelined square root of the squared distance, penetration and candidate
// choice, pipelined division for the horizontal push, and the output stage.
// ----------------------------------------------------------------------------
module cpm_back (
	input  logic                clk,
	input  logic                arst_n,
	input  cpm_pkg::cpm_item_t  head,
	input  cpm_pkg::cpm_qstat_t qstat,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                colliding,
	output logic signed [31:0]  push_x,
	output logic signed [31:0]  push_y,
	output logic signed [31:0]  push_z
);
	import cpm_pkg::*;

	logic        adv;

	logic        sq_v_s    [SQ_STEPS+1];
	cpm_item_t   sq_item_s [SQ_STEPS+1];
	logic [33:0] sq_rem_s  [SQ_STEPS+1];
	logic [31:0] sq_root_s [SQ_STEPS+1];
	logic [33:0] sq_rem_n  [SQ_STEPS];
	logic [31:0] sq_root_n [SQ_STEPS];

	logic        v_p1;
	cpm_item_t   item_p1;
	logic [31:0] len_p1, pen_p1;
	logic        horiz_p1;

	logic        dv_v_s    [DV_STEPS+1];
	cpm_dv_t     dv_s      [DV_STEPS+1];
	logic [31:0] dv_rx_s   [DV_STEPS+1];
	logic [31:0] dv_rz_s   [DV_STEPS+1];
	logic [31:0] dv_qx_s   [DV_STEPS+1];
	logic [31:0] dv_qz_s   [DV_STEPS+1];
	logic [31:0] dv_rx_n   [DV_STEPS];
	logic [31:0] dv_rz_n   [DV_STEPS];
	logic [31:0] dv_qx_n   [DV_STEPS];
	logic [31:0] dv_qz_n   [DV_STEPS];

	logic [63:0] prod_x, prod_z;

	logic               out_v_q, coll_q;
	logic signed [31:0] px_q, py_q, pz_q;
	logic signed [31:0] px_n, py_n, pz_n;

	// The whole back pipeline moves together whenever the output register
	// can take a new result.
	assign adv = !out_v_q || !out_stall;
	assign pop = adv && qstat.nempty;

	// One root bit per stage: bring down two radicand bits, try 4r+1.
	always_comb begin
		logic [33:0] tmp;
		logic [33:0] trial;
		logic        ge;
		for (int k = 0; k < SQ_STEPS; k++) begin
			tmp   = {sq_rem_s[k][31:0], sq_item_s[k].lsq[2*(SQ_STEPS-1-k) +: 2]};
			trial = {sq_root_s[k], 2'b01};
			ge    = (tmp >= trial);
			sq_rem_n[k]  = ge ? (tmp - trial) : tmp;
			sq_root_n[k] = {sq_root_s[k][30:0], ge};
		end
	end

	// One quotient bit per stage: the partial remainder stays below len.
	always_comb begin
		logic [32:0] tx, tz;
		logic        gx, gz;
		for (int k = 0; k < DV_STEPS; k++) begin
			tx = {dv_rx_s[k], dv_s[k].nx[DV_STEPS-1-k]};
			tz = {dv_rz_s[k], dv_s[k].nz[DV_STEPS-1-k]};
			gx = (tx >= {1'b0, dv_s[k].len});
			gz = (tz >= {1'b0, dv_s[k].len});
			dv_rx_n[k] = gx ? 32'(tx - {1'b0, dv_s[k].len}) : tx[31:0];
			dv_rz_n[k] = gz ? 32'(tz - {1'b0, dv_s[k].len}) : tz[31:0];
			dv_qx_n[k] = {dv_qx_s[k][30:0], gx};
			dv_qz_n[k] = {dv_qz_s[k][30:0], gz};
		end
	end

	assign prod_x = item_p1.mx * pen_p1;
	assign prod_z = item_p1.mz * pen_p1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= SQ_STEPS; k++) begin
				sq_v_s[k] <= 1'b0;
			end
			for (int k = 0; k <= DV_STEPS; k++) begin
				dv_v_s[k] <= 1'b0;
			end
			v_p1    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			sq_v_s[0] <= qstat.nempty;
			for (int k = 0; k < SQ_STEPS; k++) begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
			v_p1      <= sq_v_s[SQ_STEPS];
			dv_v_s[0] <= v_p1;
			for (int k = 0; k < DV_STEPS; k++) begin
				dv_v_s[k+1] <= dv_v_s[k];
			end
			out_v_q <= dv_v_s[DV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_item_s[0] <= head;
			sq_rem_s[0]  <= '0;
			sq_root_s[0] <= '0;
			for (int k = 0; k < SQ_STEPS; k++) begin
				sq_item_s[k+1] <= sq_item_s[k];
				sq_rem_s[k+1]  <= sq_rem_n[k];
				sq_root_s[k+1] <= sq_root_n[k];
			end

			item_p1  <= sq_item_s[SQ_STEPS];
			len_p1   <= sq_root_s[SQ_STEPS];
			pen_p1   <= sq_item_s[SQ_STEPS].rsum - sq_root_s[SQ_STEPS];
			// Ties go to the vertical push, as do coincident centers.
			horiz_p1 <= !sq_item_s[SQ_STEPS].zero
				&& ((sq_item_s[SQ_STEPS].rsum - sq_root_s[SQ_STEPS])
				< sq_item_s[SQ_STEPS].vmag);

			dv_s[0].hit   <= item_p1.hit;
			dv_s[0].horiz <= horiz_p1;
			dv_s[0].sx    <= item_p1.sx;
			dv_s[0].sz    <= item_p1.sz;
			dv_s[0].vert  <= item_p1.vert;
			dv_s[0].len   <= len_p1;
			dv_s[0].nx    <= prod_x;
			dv_s[0].nz    <= prod_z;
			dv_rx_s[0]    <= prod_x[63:32];
			dv_rz_s[0]    <= prod_z[63:32];
			dv_qx_s[0]    <= '0;
			dv_qz_s[0]    <= '0;
			for (int k = 0; k < DV_STEPS; k++) begin
				dv_s[k+1]    <= dv_s[k];
				dv_rx_s[k+1] <= dv_rx_n[k];
				dv_rz_s[k+1] <= dv_rz_n[k];
				dv_qx_s[k+1] <= dv_qx_n[k];
				dv_qz_s[k+1] <= dv_qz_n[k];
			end

			coll_q <= dv_s[DV_STEPS].hit;
			px_q   <= px_n;
			py_q   <= py_n;
			pz_q   <= pz_n;
		end
	end

	// Sign and saturation of the chosen candidate.
	always_comb begin
		cpm_dv_t     d;
		logic [31:0] qx, qz;
		d    = dv_s[DV_STEPS];
		qx   = dv_qx_s[DV_STEPS];
		qz   = dv_qz_s[DV_STEPS];
		px_n = '0;
		py_n = '0;
		pz_n = '0;
		if (d.hit) begin
			if (d.horiz) begin
				if (!d.sx) begin
					px_n = qx[31] ? 32'sh7fffffff : $signed(qx);
				end else begin
					px_n = (qx > 32'h80000000) ? 32'sh80000000 : $signed(-qx);
				end
				if (!d.sz) begin
					pz_n = qz[31] ? 32'sh7fffffff : $signed(qz);
				end else begin
					pz_n = (qz > 32'h80000000) ? 32'sh80000000 : $signed(-qz);
				end
			end else begin
				if (d.vert > 33'sh07fffffff) begin
					py_n = 32'sh7fffffff;
				end else if (d.vert < -33'sh080000000) begin
					py_n = 32'sh80000000;
				end else begin
					py_n = d.vert[31:0];
				end
			end
		end
	end

	assign out_valid = out_v_q;
	assign colliding = coll_q;
	assign push_x    = px_q;
	assign push_y    = py_q;
	assign push_z    = pz_q;

endmodule

// ----- src/cylinder_pair_mtv_unit.sv -----
// ----------------------------------------------------------------------------
// cylinder_pair_mtv_unit: push vector between two upright cylinders
// An input item holds two cylinders (center x and z, radius, bottom, top in
// Q16.16). The result item says whether they collide and gives the smallest
// translation that separates them, either horizontal or vertical.
// Channels: in_valid/in_stall take one pair per item; out_valid/out_stall
// deliver one result per pair, in order.
// A pair accepted at the input passes through three front stages, the queue,
// 33 root stages, the penetration stage, 33 product and quotient stages and
// the output register before out_valid rises with its result.
// Throughput is one item per cycle while out_stall is low; the bit-per-stage
// root and quotient pipelines set the depth, not the rate.
// When out_stall is high while out_valid is high the whole back pipeline
// holds; the front keeps going until the eight entry queue, counted with
// items in flight, is full, then in_stall rises.
// Reset empties the queue and clears all valid bits, dropping items in flight;
// no item is invented across it, and no result is pending afterwards.
// ----------------------------------------------------------------------------
module cylinder_pair_mtv_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] a_center_x,
	input  logic signed [31:0] a_center_z,
	input  logic        [30:0] a_radius,
	input  logic signed [31:0] a_bottom,
	input  logic signed [31:0] a_top,
	input  logic signed [31:0] b_center_x,
	input  logic signed [31:0] b_center_z,
	input  logic        [30:0] b_radius,
	input  logic signed [31:0] b_bottom,
	input  logic signed [31:0] b_top,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               colliding,
	output logic signed [31:0] push_x,
	output logic signed [31:0] push_y,
	output logic signed [31:0] push_z
);
	import cpm_pkg::*;

	logic       push_v;
	cpm_item_t  push_item;
	cpm_item_t  head;
	cpm_qstat_t qstat;
	logic       pop;

	cpm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.a_center_x (a_center_x),
		.a_center_z (a_center_z),
		.a_radius   (a_radius),
		.a_bottom   (a_bottom),
		.a_top      (a_top),
		.b_center_x (b_center_x),
		.b_center_z (b_center_z),
		.b_radius   (b_radius),
		.b_bottom   (b_bottom),
		.b_top      (b_top),
		.qstat      (qstat),
		.push_v     (push_v),
		.push_item  (push_item)
	);

	cpm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_v    (push_v),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	cpm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.colliding (colliding),
		.push_x    (push_x),
		.push_y    (push_y),
		.push_z    (push_z)
	);

`ifndef NO_ASSERTIONS
	a_no_push_without_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !colliding |-> push_x == 0 && push_y == 0 && push_z == 0)
		else $error("push vector set on a result without collision");

	a_one_direction: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && push_y != 0 |-> push_x == 0 && push_z == 0)
		else $error("vertical and horizontal push both set");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.level <= QCNT_W'(QDEPTH) && !(push_v && qstat.level == QCNT_W'(QDEPTH)))
		else $error("item queue overflow");
`endif

endmodule
